// ===== rtl/tmps_pkg.sv =====
package tmps_pkg;

  // Field widths and counts fixed by the channel formats.
  localparam int SRC_COUNT = 9;
  localparam int IDX_W     = 4;
  localparam int LINE_W    = 6;
  localparam int FIELD_W   = 6;
  localparam int LPF_W     = 5;
  localparam int WEIGHT_W  = 36;
  localparam int CFG_IDX_W = 2;
  localparam int RUN_W     = 8;

  localparam logic [WEIGHT_W-1:0] WEIGHTS_RESET = 36'd5991772981;
  localparam logic [LPF_W-1:0]    LPF_RESET     = 5'd16;
  localparam logic [FIELD_W-1:0]  FPC_RESET     = 6'd50;
  localparam logic [LINE_W-1:0]   LINE_RESET    = 6'd16;
  localparam logic [RUN_W-1:0]    QUIET_AFTER   = 8'd8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LPF     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FPC     = 2'd2;

  // Result action codes.
  localparam logic [1:0] ACT_P830  = 2'd0;
  localparam logic [1:0] ACT_MOVE  = 2'd1;
  localparam logic [1:0] ACT_QUIET = 2'd2;

  // Datapath operation selected by the current microcode word.
  typedef enum logic [2:0] {
    OP_WAIT,
    OP_SEARCH,
    OP_FIELD,
    OP_DECIDE,
    OP_DRAIN
  } op_t;

  // Conditions the datapath reports back to the sequencer.
  typedef struct packed {
    logic accept;
    logic cd_zero;
    logic drain_done;
  } status_t;

  // Effective countdown weight: streams without weight bits use 1, and 0 counts as 1.
  function automatic logic [3:0] eff_weight(input logic [WEIGHT_W-1:0] w,
                                            input logic [IDX_W-1:0] s);
    logic [3:0] raw;
    raw = '0;
    if (s < IDX_W'(SRC_COUNT)) begin
      raw = w[{s, 2'b00} +: 4];
    end
    return (raw == 4'd0) ? 4'd1 : raw;
  endfunction

endpackage

// ===== rtl/tmps_seq.sv =====
module tmps_seq (
  input  logic              clk,
  input  logic              rst,
  input  tmps_pkg::status_t status,
  output tmps_pkg::op_t     op
);
  import tmps_pkg::*;

  typedef logic [2:0] step_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_ACCEPT,
    C_CD_ZERO,
    C_DRAIN_DONE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    logic  hold;
    step_t target;
  } ucode_t;

  localparam step_t ST_WAIT   = 3'd0;
  localparam step_t ST_SEARCH = 3'd1;
  localparam step_t ST_FIELD  = 3'd2;
  localparam step_t ST_DECIDE = 3'd3;
  localparam step_t ST_DRAIN  = 3'd4;

  // The program: a taken condition jumps to target, otherwise the word either
  // repeats (hold) or falls through to the next step.
  function automatic ucode_t rom(input step_t a);
    ucode_t w;
    unique case (a)
      ST_WAIT:   w = '{op: OP_WAIT,   cond: C_ACCEPT,     hold: 1'b1, target: ST_SEARCH};
      ST_SEARCH: w = '{op: OP_SEARCH, cond: C_CD_ZERO,    hold: 1'b1, target: ST_FIELD};
      ST_FIELD:  w = '{op: OP_FIELD,  cond: C_NEVER,      hold: 1'b0, target: ST_WAIT};
      ST_DECIDE: w = '{op: OP_DECIDE, cond: C_NEVER,      hold: 1'b0, target: ST_WAIT};
      ST_DRAIN:  w = '{op: OP_DRAIN,  cond: C_DRAIN_DONE, hold: 1'b1, target: ST_WAIT};
      default:   w = '{op: OP_WAIT,   cond: C_ALWAYS,     hold: 1'b0, target: ST_WAIT};
    endcase
    return w;
  endfunction

  step_t  step;
  step_t  step_next;
  ucode_t word;
  logic   cond_met;

  assign word = rom(step);
  assign op   = word.op;

  always_comb begin
    unique case (word.cond)
      C_NEVER:      cond_met = 1'b0;
      C_ALWAYS:     cond_met = 1'b1;
      C_ACCEPT:     cond_met = status.accept;
      C_CD_ZERO:    cond_met = status.cd_zero;
      C_DRAIN_DONE: cond_met = status.drain_done;
      default:      cond_met = 1'b1;
    endcase
  end

  always_comb begin
    if (cond_met) begin
      step_next = word.target;
    end else if (word.hold) begin
      step_next = step;
    end else begin
      step_next = step + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_WAIT;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ===== rtl/tmps_datapath.sv =====
module tmps_datapath #(
  parameter int STREAM_COUNT = 9
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  tmps_pkg::op_t                         op,
  output tmps_pkg::status_t                     status,
  input  logic                                  in_valid,
  input  logic [tmps_pkg::SRC_COUNT-1:0]        source_empty,
  input  logic [tmps_pkg::SRC_COUNT-1:0]        source_header,
  input  logic                                  output_full,
  input  logic                                  cfg_wr,
  input  logic [tmps_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tmps_pkg::WEIGHT_W-1:0]         cfg_data,
  input  logic                                  out_stall,
  output logic                                  out_valid,
  output logic [1:0]                            action,
  output logic [tmps_pkg::IDX_W-1:0]            stream_index,
  output logic                                  is_header,
  output logic [tmps_pkg::LINE_W-1:0]           line_number,
  output logic [tmps_pkg::FIELD_W-1:0]          field_number,
  output logic                                  last_of_step
);
  import tmps_pkg::*;

  localparam int PTR_W = $clog2(STREAM_COUNT);

  logic [WEIGHT_W-1:0] weights;
  logic [LPF_W-1:0]    lpf;
  logic [FIELD_W-1:0]  fpc;

  logic [3:0]              countdown [STREAM_COUNT];
  logic [STREAM_COUNT-1:0] hold;
  logic [PTR_W-1:0]        ptr;
  logic [RUN_W-1:0]        hold_run;
  logic [LINE_W-1:0]       line_count;
  logic [FIELD_W-1:0]      field_count;

  logic [SRC_COUNT-1:0]    empty_q;
  logic [SRC_COUNT-1:0]    header_q;
  logic                    full_q;
  logic [STREAM_COUNT-1:0] empty_vec;
  logic [STREAM_COUNT-1:0] header_vec;

  // Up to two results per step wait here until the step is complete.
  logic [1:0]        slot_act  [2];
  logic [IDX_W-1:0]  slot_idx  [2];
  logic              slot_hdr  [2];
  logic [LINE_W-1:0] slot_line [2];
  logic [1:0]        n_res;
  logic              k;

  logic [3:0]         cd_cur;
  logic               cd_zero;
  logic [PTR_W-1:0]   ptr_inc;
  logic               field_start;
  logic [FIELD_W-1:0] fc_wrapped;
  logic               cur_held;
  logic               cur_empty;
  logic               cur_hdr;
  logic [RUN_W-1:0]   hr_inc;
  logic [LINE_W-1:0]  line_inc;
  logic               emit_move;
  logic               emit_quiet;
  logic               load_ok;
  logic               last_slot;
  logic               accept;
  logic               do_load;

  for (genvar i = 0; i < STREAM_COUNT; i++) begin : g_src
    if (i < SRC_COUNT) begin : g_in
      assign empty_vec[i]  = empty_q[i];
      assign header_vec[i] = header_q[i];
    end else begin : g_pad
      assign empty_vec[i]  = 1'b0;
      assign header_vec[i] = 1'b0;
    end
  end

  assign accept      = (op == OP_WAIT) && in_valid;
  assign cd_cur      = countdown[ptr];
  assign cd_zero     = (cd_cur == 4'd0);
  assign ptr_inc     = (ptr == PTR_W'(STREAM_COUNT - 1)) ? '0 : ptr + 1'b1;
  assign field_start = (line_count >= {1'b0, lpf});
  assign fc_wrapped  = (field_count >= fpc) ? '0 : field_count;
  assign cur_held    = hold[ptr];
  assign cur_empty   = empty_vec[ptr];
  assign cur_hdr     = header_vec[ptr];
  assign hr_inc      = (hold_run == {RUN_W{1'b1}}) ? hold_run : hold_run + 1'b1;
  assign line_inc    = line_count + 1'b1;
  assign emit_move   = !cur_held && !cur_empty && !full_q;
  assign emit_quiet  = cur_held && (hr_inc >= QUIET_AFTER) && !full_q;
  assign load_ok     = !out_valid || !out_stall;
  assign last_slot   = (({1'b0, k} + 2'd1) == n_res);
  assign do_load     = (op == OP_DRAIN) && (n_res != 2'd0) && load_ok;

  assign status.accept     = accept;
  assign status.cd_zero    = cd_zero;
  assign status.drain_done = (op == OP_DRAIN) && ((n_res == 2'd0) || (load_ok && last_slot));

  always_ff @(posedge clk) begin
    if (rst) begin
      weights <= WEIGHTS_RESET;
      lpf     <= LPF_RESET;
      fpc     <= FPC_RESET;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_WEIGHTS: weights <= cfg_data;
        REG_LPF:     lpf     <= cfg_data[LPF_W-1:0];
        REG_FPC:     fpc     <= cfg_data[FIELD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STREAM_COUNT; i++) begin
        countdown[i] <= eff_weight(WEIGHTS_RESET, IDX_W'(i));
      end
    end else if ((op == OP_SEARCH) && !cd_zero) begin
      countdown[ptr] <= cd_cur - 4'd1;
    end else if (op == OP_DECIDE) begin
      countdown[ptr] <= eff_weight(weights, IDX_W'(ptr));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr         <= '0;
      hold        <= '0;
      hold_run    <= '0;
      line_count  <= LINE_RESET;
      field_count <= '0;
      n_res       <= '0;
      k           <= 1'b0;
    end else begin
      case (op)
        OP_SEARCH: begin
          if (!cd_zero) begin
            ptr <= ptr_inc;
          end
        end
        OP_FIELD: begin
          if (field_start) begin
            hold        <= '0;
            field_count <= fc_wrapped + 1'b1;
            if (fc_wrapped == '0) begin
              line_count <= 6'd1;
              n_res      <= 2'd1;
            end else begin
              line_count <= '0;
            end
          end
        end
        OP_DECIDE: begin
          k <= 1'b0;
          if (!cur_held) begin
            hold_run <= '0;
            if (cur_empty || (!full_q && cur_hdr)) begin
              hold[ptr] <= 1'b1;
            end
          end else begin
            hold_run <= hr_inc;
          end
          if (emit_move || emit_quiet) begin
            line_count <= line_inc;
            n_res      <= n_res + 2'd1;
          end
        end
        OP_DRAIN: begin
          if (do_load) begin
            k <= ~k;
          end
          if (status.drain_done) begin
            n_res <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      empty_q  <= source_empty;
      header_q <= source_header;
      full_q   <= output_full;
    end
    if ((op == OP_FIELD) && field_start && (fc_wrapped == '0)) begin
      slot_act[0]  <= ACT_P830;
      slot_idx[0]  <= '0;
      slot_hdr[0]  <= 1'b0;
      slot_line[0] <= 6'd1;
    end
    if ((op == OP_DECIDE) && (emit_move || emit_quiet)) begin
      slot_act[n_res[0]]  <= emit_move ? ACT_MOVE : ACT_QUIET;
      slot_idx[n_res[0]]  <= emit_move ? IDX_W'(ptr) : '0;
      slot_hdr[n_res[0]]  <= emit_move && cur_hdr;
      slot_line[n_res[0]] <= line_inc;
    end
    if (do_load) begin
      action       <= slot_act[k];
      stream_index <= slot_idx[k];
      is_header    <= slot_hdr[k];
      line_number  <= slot_line[k];
      field_number <= field_count;
      last_of_step <= last_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/teletext_magazine_packet_scheduler_unit.sv =====
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  source_empty, source_header, output_full
// output    out        out_valid/out_stall  action, stream_index, is_header,
//                                           line_number, field_number, last_of_step
// config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One scheduling step runs the search, field, decide and drain words once it is
// accepted. The search moves the ring pointer past D non-zero countdowns (at
// most 15 per stream), one stream per cycle, decrementing each, and the drain
// hands out R results (0 to 2), waiting while the output is stalled.
// Reset is synchronous and active high; it restores the default registers and
// loads every countdown from the default weights. No clearing pass is needed.
// A stalled result sits in the output register; the next step can be accepted
// while it waits, but its own results are only loaded once that one is taken.
module teletext_magazine_packet_scheduler_unit #(
  parameter int STREAM_COUNT = 9
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [tmps_pkg::SRC_COUNT-1:0]  source_empty,
  input  logic [tmps_pkg::SRC_COUNT-1:0]  source_header,
  input  logic                            output_full,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      action,
  output logic [tmps_pkg::IDX_W-1:0]      stream_index,
  output logic                            is_header,
  output logic [tmps_pkg::LINE_W-1:0]     line_number,
  output logic [tmps_pkg::FIELD_W-1:0]    field_number,
  output logic                            last_of_step,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tmps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tmps_pkg::WEIGHT_W-1:0]   cfg_data
);
  import tmps_pkg::*;

  op_t     op;
  status_t status;
  logic    cfg_wr;

  // Register writes are always taken; the datapath registers them at the next clock edge.
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // New steps are only taken while the program sits on its wait word.
  assign in_stall = (op != OP_WAIT);

  // The sequencer walks the control program: wait, search the ring, field
  // bookkeeping, stream decision, then hand out the collected results.
  tmps_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .op     (op)
  );

  // The datapath holds the countdowns, holds, counters, result slots and the
  // output register, and carries out whatever operation the program selects.
  tmps_datapath #(
    .STREAM_COUNT (STREAM_COUNT)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .op            (op),
    .status        (status),
    .in_valid      (in_valid),
    .source_empty  (source_empty),
    .source_header (source_header),
    .output_full   (output_full),
    .cfg_wr        (cfg_wr),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .action        (action),
    .stream_index  (stream_index),
    .is_header     (is_header),
    .line_number   (line_number),
    .field_number  (field_number),
    .last_of_step  (last_of_step)
  );

endmodule

// ===== rtl/tmps_checker.sv =====
module tmps_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [1:0]                  action,
  input logic [tmps_pkg::IDX_W-1:0]  stream_index,
  input logic                        is_header,
  input logic [tmps_pkg::LINE_W-1:0] line_number
);
  import tmps_pkg::*;

  // A stalled result must be held unchanged.
  a_hold_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(action) && $stable(stream_index)
      && $stable(line_number))
    else $error("stalled result changed");

  // Steps are handled one at a time: after a transaction the input stalls.
  a_one_step: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second step taken while one is in work");

  // Only the three defined actions ever appear.
  a_action_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (action == ACT_P830) || (action == ACT_MOVE) || (action == ACT_QUIET))
    else $error("undefined action code");

  // Inserted packets carry stream zero and no header mark.
  a_inserted: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action != ACT_MOVE) |-> (stream_index == '0) && !is_header)
    else $error("inserted packet has stream or header set");

  // The forced packet always opens a field, so it is on line one.
  a_p830_line: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action == ACT_P830) |-> (line_number == 6'd1))
    else $error("forced packet not on first line");

endmodule

bind teletext_magazine_packet_scheduler_unit tmps_checker u_tmps_checker (.*);
